@@ rtl/pldc_pkg.sv @@
// ----------------------------------------------------------------------------
// Phase lock delay controller package
// Shared widths, limits, register indexes and helper functions.
// ----------------------------------------------------------------------------
package pldc_pkg;

	// Stream and configuration port widths.
	localparam int IN_DATA_W  = 72;
	localparam int OUT_DATA_W = 80;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// Default number of quiet windows needed to lock.
	localparam int unsigned QUIET_NEEDED_DEF = 3;

	// Delay line and frequency offset limits.
	localparam logic [4:0]        MAX_TAP    = 5'd16;
	localparam logic signed [3:0] OFFSET_MAX = 4'sd5;
	localparam logic signed [3:0] OFFSET_MIN = -4'sd5;

	// A window is quiet only while |slope| stays below 100 mV/s in Q15.8.
	localparam logic [22:0] SLOPE_LIMIT = 23'd25600;

	// Integrator clamp of 16 taps in Q5.16.
	localparam logic signed [23:0] INTEG_LIMIT = 24'sd1048576;

	// Half a tap in units of 1/327680 tap, the rounding threshold.
	localparam logic signed [31:0] HALF_CORR = 32'sd163840;

	// Reciprocal of ten for the integrator increment: floor(x * R >> 30).
	localparam int          RECIP_SHIFT = 30;
	localparam logic [26:0] RECIP_TEN   = 27'd107374183;

	// Reset values of the threshold registers.
	localparam logic [15:0] DEAD_BAND_RST = 16'd1280;
	localparam logic [15:0] RMS_QUIET_RST = 16'd2560;

	// Delay step codes.
	localparam logic signed [1:0] STEP_DOWN = -2'sd1;
	localparam logic signed [1:0] STEP_NONE = 2'sd0;
	localparam logic signed [1:0] STEP_UP   = 2'sd1;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BASE_CH0_LO,
		REG_BASE_CH1_LO,
		REG_BASE_CH0_HI,
		REG_BASE_CH1_HI,
		REG_START_CH0,
		REG_START_CH1,
		REG_DEAD_BAND,
		REG_RMS_QUIET
	} cfg_reg_t;

	// Limit a start tap to the end of the delay line.
	function automatic logic [4:0] clamp_tap(input logic [4:0] d);
		return (d > MAX_TAP) ? MAX_TAP : d;
	endfunction

	// Add a signed offset to a base word, saturating to the 32-bit range.
	function automatic logic [31:0] sat_word(input logic [31:0] base,
		input logic signed [3:0] off);
		logic signed [33:0] sum;
		sum = $signed({2'b00, base}) + 34'(off);
		if (sum[33]) begin
			return 32'd0;
		end else if (sum[32]) begin
			return 32'hFFFF_FFFF;
		end
		return sum[31:0];
	endfunction

endpackage

@@ rtl/phase_lock_delay_controller.sv @@
// ----------------------------------------------------------------------------
// Phase lock delay controller
// Two-channel lock loop on window metrics driving delay taps and DDS words.
// ----------------------------------------------------------------------------
// The block takes one window transfer per clock while the output is not
// stalled and returns one result per window, in order. Stage one computes the
// error against the channel target and the PI increment (one reciprocal
// multiply), stage two reads and updates the channel state (lock, quiet
// count, integrator, tap and offset), stage three holds the step result and
// the output register adds the offset to the base words. A window that locks
// a channel hands its mean straight to the next window of that channel, so
// any mix of channels streams at full rate. A configuration write
// re-initialises both channels and must only be issued while no window is in
// flight.
module phase_lock_delay_controller
	import pldc_pkg::*;
#(
	parameter int unsigned QUIET_NEEDED = QUIET_NEEDED_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// Configuration write port.
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// Window stream in.
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// window_mean[22:0], window_rms[44:23], window_slope[67:45], zero pad
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// channel[0]
	input  logic [0:0]            s_tuser,
	// Result stream out.
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// locked[0], delay_tap[5:1], word_offset[9:6], step_taken[11:10],
	// freq_word_first[43:12], freq_word_second[75:44], zero pad
	output logic [OUT_DATA_W-1:0] m_tdata,
	// channel_out[0]
	output logic [0:0]            m_tuser
);

	localparam int QC_W = $clog2(QUIET_NEEDED + 1);
	localparam logic [QC_W-1:0] QUIET_GOAL = QC_W'(QUIET_NEEDED);

	// Configuration registers.
	logic [31:0] base_lo_q [2];
	logic [31:0] base_hi_q [2];
	logic [4:0]  start_q [2];
	logic [15:0] dead_band_q;
	logic [15:0] rms_thr_q;

	// Per-channel loop state.
	logic                    lock_q [2];
	logic [QC_W-1:0]         qc_q [2];
	logic signed [22:0]      target_q [2];
	logic signed [21:0]      integ_q [2];
	logic [4:0]              tap_q [2];
	logic signed [3:0]       off_q [2];

	// Pipeline valids and flow control.
	logic s1_valid_q, s2_valid_q, s3_valid_q, out_valid_q;
	logic out_free, s3_free, s2_free, s1_free;
	logic s2_adv, s1_adv, in_xfer;

	// Stage one registers.
	logic               ch_s1;
	logic signed [22:0] mean_s1;
	logic [21:0]        rms_s1;
	logic signed [22:0] slope_s1;

	// Stage two registers.
	logic               ch_s2;
	logic signed [22:0] mean_s2;
	logic               quiet_s2;
	logic signed [23:0] err_s2;
	logic signed [22:0] inc_s2;

	// Stage three registers.
	logic               ch_s3;
	logic               locked_s3;
	logic [4:0]         tap_s3;
	logic signed [3:0]  off_s3;
	logic signed [1:0]  step_s3;

	// Output registers.
	logic               ch_q;
	logic               locked_q;
	logic [4:0]         tap_out_q;
	logic signed [3:0]  off_out_q;
	logic signed [1:0]  step_q;
	logic [31:0]        word_lo_q;
	logic [31:0]        word_hi_q;

	// Stage one combinational signals.
	logic               fwd;
	logic signed [22:0] tgt;
	logic signed [23:0] err_raw;
	logic [23:0]        aerr;
	logic               in_band;
	logic [23:0]        mag;
	logic               big;
	logic [25:0]        x_num;
	logic [52:0]        prod;
	logic [22:0]        quot;
	logic [21:0]        inc_mag;
	logic signed [22:0] inc_val;
	logic signed [23:0] err_val;
	logic [22:0]        aslope;
	logic               quiet;

	// Stage two combinational signals.
	logic                lock_rd;
	logic [QC_W-1:0]     qc_rd;
	logic signed [21:0]  integ_rd;
	logic [4:0]          tap_rd;
	logic signed [3:0]   off_rd;
	logic [QC_W-1:0]     qc_inc;
	logic signed [23:0]  integ_sum;
	logic signed [21:0]  integ_cl;
	logic signed [31:0]  s_val;
	logic                lock_nx;
	logic [QC_W-1:0]     qc_nx;
	logic signed [21:0]  integ_nx;
	logic                tgt_capture;
	logic signed [1:0]   step;
	logic [4:0]          tap_nx;
	logic signed [3:0]   off_nx;

	// Start taps as they stand after a configuration write.
	logic [4:0] start0_nx, start1_nx;

	// Flow control: each stage moves when the next one is empty or moving.
	assign out_free = !out_valid_q || m_tready;
	assign s3_free  = !s3_valid_q || out_free;
	assign s2_free  = !s2_valid_q || s3_free;
	assign s1_free  = !s1_valid_q || s2_free;
	assign s2_adv   = s2_valid_q && s3_free;
	assign s1_adv   = s1_valid_q && s2_free;
	assign s_tready = s1_free;
	assign in_xfer  = s_tvalid && s1_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			s2_valid_q  <= 1'b0;
			s3_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_free) begin
				s1_valid_q <= s_tvalid;
			end
			if (s2_free) begin
				s2_valid_q <= s1_valid_q;
			end
			if (s3_free) begin
				s3_valid_q <= s2_valid_q;
			end
			if (out_free) begin
				out_valid_q <= s3_valid_q;
			end
		end
	end

	// Configuration register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_lo_q[0] <= '0;
			base_lo_q[1] <= '0;
			base_hi_q[0] <= '0;
			base_hi_q[1] <= '0;
			start_q[0]   <= '0;
			start_q[1]   <= '0;
			dead_band_q  <= DEAD_BAND_RST;
			rms_thr_q    <= RMS_QUIET_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_BASE_CH0_LO: base_lo_q[0] <= cfg_data;
				REG_BASE_CH1_LO: base_lo_q[1] <= cfg_data;
				REG_BASE_CH0_HI: base_hi_q[0] <= cfg_data;
				REG_BASE_CH1_HI: base_hi_q[1] <= cfg_data;
				REG_START_CH0:   start_q[0]   <= cfg_data[4:0];
				REG_START_CH1:   start_q[1]   <= cfg_data[4:0];
				REG_DEAD_BAND:   dead_band_q  <= cfg_data[15:0];
				REG_RMS_QUIET:   rms_thr_q    <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	assign start0_nx = (cfg_reg_t'(cfg_index) == REG_START_CH0) ? cfg_data[4:0] : start_q[0];
	assign start1_nx = (cfg_reg_t'(cfg_index) == REG_START_CH1) ? cfg_data[4:0] : start_q[1];

	// Input register.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			ch_s1    <= s_tuser[0];
			mean_s1  <= $signed(s_tdata[22:0]);
			rms_s1   <= s_tdata[44:23];
			slope_s1 <= $signed(s_tdata[67:45]);
		end
	end

	// Stage one: error against the target, dead band, PI increment and quiet test.
	// A window in stage two that is about to lock this channel supplies the
	// target, since its capture lands in the same edge this window moves on.
	always_comb begin
		fwd     = s2_valid_q && (ch_s2 == ch_s1) && !lock_rd;
		tgt     = fwd ? mean_s2 : target_q[ch_s1];
		err_raw = 24'(mean_s1) - 24'(tgt);
		aerr    = err_raw[23] ? 24'(-err_raw) : err_raw;
		in_band = aerr < {8'd0, dead_band_q};
		mag     = in_band ? 24'd0 : aerr;
		err_val = in_band ? 24'sd0 : err_raw;
		// Past 2^18 the increment alone drives the integrator into its clamp.
		big     = |mag[23:18];
		x_num   = {1'b0, mag[17:0], 7'd0} + 26'd5;
		prod    = 53'(x_num) * 53'(RECIP_TEN);
		quot    = prod[RECIP_SHIFT +: 23];
		inc_mag = (big || (|quot[22:21])) ? 22'h20_0000 : quot[21:0];
		inc_val = err_raw[23] ? -$signed({1'b0, inc_mag}) : $signed({1'b0, inc_mag});
		aslope  = slope_s1[22] ? 23'(-slope_s1) : 23'(slope_s1);
		quiet   = (rms_s1 < {6'd0, rms_thr_q}) && (aslope < SLOPE_LIMIT);
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			ch_s2    <= ch_s1;
			mean_s2  <= mean_s1;
			quiet_s2 <= quiet;
			err_s2   <= err_val;
			inc_s2   <= inc_val;
		end
	end

	// Stage two: read the channel state.
	assign lock_rd  = lock_q[ch_s2];
	assign qc_rd    = qc_q[ch_s2];
	assign integ_rd = integ_q[ch_s2];
	assign tap_rd   = tap_q[ch_s2];
	assign off_rd   = off_q[ch_s2];

	// Stage two: lock search or PI update, then the tap step with carry.
	always_comb begin
		qc_inc    = (qc_rd < QUIET_GOAL) ? qc_rd + 1'b1 : qc_rd;
		integ_sum = 24'(integ_rd) + 24'(inc_s2);
		if (integ_sum > INTEG_LIMIT) begin
			integ_cl = 22'(INTEG_LIMIT);
		end else if (integ_sum < -INTEG_LIMIT) begin
			integ_cl = 22'(-INTEG_LIMIT);
		end else begin
			integ_cl = integ_sum[21:0];
		end
		s_val = (32'(integ_cl) <<< 2) + 32'(integ_cl) - (32'(err_s2) <<< 7);

		lock_nx     = lock_rd;
		qc_nx       = qc_rd;
		integ_nx    = integ_rd;
		tgt_capture = 1'b0;
		step        = STEP_NONE;
		if (!lock_rd) begin
			if (quiet_s2) begin
				qc_nx = qc_inc;
				if (qc_inc >= QUIET_GOAL) begin
					lock_nx     = 1'b1;
					tgt_capture = 1'b1;
					integ_nx    = '0;
				end
			end else begin
				qc_nx = '0;
				step  = STEP_UP;
			end
		end else begin
			integ_nx = integ_cl;
			if (s_val >= HALF_CORR) begin
				step = STEP_DOWN;
			end else if (s_val <= -HALF_CORR) begin
				step = STEP_UP;
			end
		end

		// Tap move; running off either end carries into the offset.
		tap_nx = tap_rd;
		off_nx = off_rd;
		case (step)
			STEP_UP: begin
				if (tap_rd == MAX_TAP) begin
					if (off_rd > OFFSET_MIN) begin
						off_nx = off_rd - 4'sd1;
						tap_nx = '0;
					end
				end else begin
					tap_nx = tap_rd + 5'd1;
				end
			end
			STEP_DOWN: begin
				if (tap_rd == '0) begin
					if (off_rd < OFFSET_MAX) begin
						off_nx = off_rd + 4'sd1;
						tap_nx = MAX_TAP;
					end
				end else begin
					tap_nx = tap_rd - 5'd1;
				end
			end
			default: ;
		endcase

		// Anti-windup: hold the integrator when pinned against a limit.
		if (lock_rd && (((off_nx == OFFSET_MAX) && (step == STEP_DOWN) && (tap_nx == '0)) ||
			((off_nx == OFFSET_MIN) && (step == STEP_UP) && (tap_nx == MAX_TAP)))) begin
			integ_nx = integ_rd;
		end
	end

	// Channel state update; a configuration write re-initialises both channels.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < 2; c++) begin
				lock_q[c]   <= 1'b0;
				qc_q[c]     <= '0;
				target_q[c] <= '0;
				integ_q[c]  <= '0;
				tap_q[c]    <= '0;
				off_q[c]    <= '0;
			end
		end else if (cfg_we) begin
			for (int c = 0; c < 2; c++) begin
				lock_q[c]   <= 1'b0;
				qc_q[c]     <= '0;
				target_q[c] <= '0;
				integ_q[c]  <= '0;
				off_q[c]    <= '0;
			end
			tap_q[0] <= clamp_tap(start0_nx);
			tap_q[1] <= clamp_tap(start1_nx);
		end else if (s2_adv) begin
			lock_q[ch_s2]  <= lock_nx;
			qc_q[ch_s2]    <= qc_nx;
			integ_q[ch_s2] <= integ_nx;
			tap_q[ch_s2]   <= tap_nx;
			off_q[ch_s2]   <= off_nx;
			if (tgt_capture) begin
				target_q[ch_s2] <= mean_s2;
			end
		end
	end

	// Stage three register.
	always_ff @(posedge clk) begin
		if (s2_adv) begin
			ch_s3     <= ch_s2;
			locked_s3 <= lock_nx;
			tap_s3    <= tap_nx;
			off_s3    <= off_nx;
			step_s3   <= step;
		end
	end

	// Output register with saturated generator words.
	always_ff @(posedge clk) begin
		if (s3_valid_q && out_free) begin
			ch_q      <= ch_s3;
			locked_q  <= locked_s3;
			tap_out_q <= tap_s3;
			off_out_q <= off_s3;
			step_q    <= step_s3;
			word_lo_q <= sat_word(base_lo_q[ch_s3], off_s3);
			word_hi_q <= sat_word(base_hi_q[ch_s3], off_s3);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = ch_q;
	assign m_tdata  = {4'd0, word_hi_q, word_lo_q, step_q, off_out_q, tap_out_q, locked_q};

	// Taps never leave the delay line.
	a_tap_range: assert property (@(posedge clk) disable iff (!arst_n)
		(tap_q[0] <= MAX_TAP) && (tap_q[1] <= MAX_TAP))
		else $error("delay tap beyond end of line");

	// Offsets stay within their limits.
	a_off_range: assert property (@(posedge clk) disable iff (!arst_n)
		(off_q[0] >= OFFSET_MIN) && (off_q[0] <= OFFSET_MAX) &&
		(off_q[1] >= OFFSET_MIN) && (off_q[1] <= OFFSET_MAX))
		else $error("frequency offset beyond limit");

	// The integrator never escapes its clamp.
	a_integ_range: assert property (@(posedge clk) disable iff (!arst_n)
		(24'(integ_q[0]) <= INTEG_LIMIT) && (24'(integ_q[0]) >= -INTEG_LIMIT) &&
		(24'(integ_q[1]) <= INTEG_LIMIT) && (24'(integ_q[1]) >= -INTEG_LIMIT))
		else $error("integrator beyond clamp");

	// An unlocked channel only ever steps its tap upward.
	a_unlocked_step: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !locked_q) |-> (step_q != STEP_DOWN))
		else $error("downward step reported while unlocked");

	// A window that stays in stage three while the output stalls keeps its result in place.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(s3_valid_q && out_valid_q && !m_tready) |=> (s3_valid_q && $stable(step_s3)))
		else $error("stage three changed while the output stalled");

endmodule
